[design/rsic_pkg.sv]
// ============================================================================
// rsic_pkg
// Shared types and constants for the reservation station issue/complete core.
// ============================================================================
package rsic_pkg;

    localparam int CmdW = 2;
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_PRESET   = 2'd2;

    localparam logic [2:0] KIND_ISSUED    = 3'd0;
    localparam logic [2:0] KIND_COMPLETED = 3'd1;
    localparam logic [2:0] KIND_FREED     = 3'd2;
    localparam logic [2:0] KIND_SUMMARY   = 3'd3;
    localparam logic [2:0] KIND_DISPATCH  = 3'd4;

    localparam logic REG_ISSUE_WIDTH  = 1'b0;
    localparam logic REG_EXEC_LATENCY = 1'b1;

    // Input word fields, from the highest bit down.
    typedef struct packed {
        logic [7:0] preset_count;
        logic       preset_valid;
        logic       dst_used;
        logic [5:0] dst_reg;
        logic       src_b_used;
        logic [5:0] src_b;
        logic       src_a_used;
        logic [5:0] src_a;
        logic [7:0] op_tag;
        logic [1:0] command;
    } in_word_t;

    typedef struct packed {
        logic [4:0] busy_units;
        logic [4:0] occupancy;
        logic       accepted;
        logic [5:0] freed_reg;
        logic [7:0] out_tag;
        logic [2:0] kind;
    } out_word_t;

endpackage

[design/rsic_ram.sv]
// ============================================================================
// rsic_ram
// Generic single-port RAM with a registered read.
// ============================================================================
module rsic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[design/reservation_station_issue_complete_core.sv]
// ============================================================================
// reservation_station_issue_complete_core
// Reservation station with wakeup/select and a physical-register scoreboard.
// ============================================================================
// A tick walks the slots twice, first to issue and then to retire. Each
// issued op emits an issue word, and each retired op emits its completion
// word and then does a read-modify-write of the scoreboard for each of its
// two sources. Each freed register emits a further word. A finished word
// waits for the output register to be free. The input is not ready while
// a command is handled.
// Result words carry tuser = kind and tlast on the final word of each command.
module reservation_station_issue_complete_core #(
    parameter int STATION_SLOTS  = 16,
    parameter int PHYS_REG_COUNT = 64,
    parameter int MAX_ISSUE      = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command, op_tag, src_a, src_a_used, src_b, src_b_used, dst_reg,
    // dst_used, preset_valid, preset_count (lowest bit up), 40 bits
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_tag, freed_reg, accepted, occupancy, busy_units (lowest bit up)
    output logic [31:0] m_tdata,
    // kind
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata
);
    import rsic_pkg::*;

    localparam int SW = $clog2(STATION_SLOTS);
    localparam int CW = $clog2(STATION_SLOTS + 1);
    localparam int RW = (PHYS_REG_COUNT > 64) ? $clog2(PHYS_REG_COUNT) : 6;
    localparam int AW = $clog2(PHYS_REG_COUNT);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISP, ST_PRESET, ST_ISCAN, ST_ISCAN_W, ST_RSCAN, ST_RSCAN_W,
        ST_SRC_RD, ST_SRC_W, ST_SRC_WB, ST_SUMMARY, ST_EMIT
    } state_t;

    state_t state_reg, ret_reg;
    in_word_t in_reg;
    in_word_t s_word;
    logic [2:0]  iw_reg;
    logic [3:0]  lat_reg;
    logic [31:0] now_reg;
    logic [STATION_SLOTS-1:0] busy_reg, issued_reg;
    logic [PHYS_REG_COUNT-1:0] rdy_reg;
    logic [SW-1:0] idx_reg;
    logic [3:0] budget_reg;
    logic [CW-1:0] busyu_reg;
    logic src_sel_reg;
    logic [RW-1:0] sreg_reg;
    logic srcv_reg;
    out_word_t ow_reg;
    out_word_t pend_reg;
    logic last_reg;
    logic pend_last_reg;
    logic ovalid_reg;

    assign s_word = s_tdata;

    // Slot memory: tag, sources, dest, done time.
    localparam int SLW = 8 + 14 + 7 + 32;
    logic slot_we;
    logic [SW-1:0] slot_addr;
    logic [SLW-1:0] slot_wd, slot_rd;
    rsic_ram #(.WIDTH(SLW), .DEPTH(STATION_SLOTS)) u_slot (
        .aclk(aclk), .we(slot_we), .addr(slot_addr), .wdata(slot_wd), .rdata(slot_rd)
    );
    logic [7:0]  rd_tag;
    logic [13:0] rd_src;
    logic [6:0]  rd_dst;
    logic [31:0] rd_done;
    assign {rd_done, rd_dst, rd_src, rd_tag} = slot_rd;

    // Users counts; valid bits give the zero reset value.
    logic [PHYS_REG_COUNT-1:0] uval_reg;
    logic u_we;
    logic [AW-1:0] u_addr;
    logic [7:0] u_wd, u_rd;
    rsic_ram #(.WIDTH(8), .DEPTH(PHYS_REG_COUNT)) u_users (
        .aclk(aclk), .we(u_we), .addr(u_addr), .wdata(u_wd), .rdata(u_rd)
    );

    function automatic logic rd_ready(input logic [RW-1:0] r,
                                      input logic [PHYS_REG_COUNT-1:0] v);
        logic ok;
        ok = 1'b1;
        if (32'(r) < PHYS_REG_COUNT) begin
            ok = v[AW'(r)];
        end
        return ok;
    endfunction

    logic [SW-1:0] free_idx;
    logic free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = STATION_SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic src_a_ok, src_b_ok;
    assign src_a_ok = !rd_src[6] || rd_ready(RW'(rd_src[5:0]), rdy_reg);
    assign src_b_ok = !rd_src[13] || rd_ready(RW'(rd_src[12:7]), rdy_reg);

    logic [7:0] u_cur, u_dec;
    assign u_cur = uval_reg[AW'(sreg_reg)] ? u_rd : 8'd0;
    assign u_dec = (u_cur != 8'd0) ? u_cur - 8'd1 : 8'd0;

    logic [6:0] cur_src;
    assign cur_src = src_sel_reg ? rd_src[13:7] : rd_src[6:0];

    always_comb begin
        slot_we   = 1'b0;
        slot_addr = idx_reg;
        slot_wd   = slot_rd;
        u_we      = 1'b0;
        u_addr    = AW'(sreg_reg);
        u_wd      = u_dec;
        unique case (state_reg)
            ST_IDLE: begin
                slot_addr = free_idx;
                u_addr = AW'(s_word.dst_reg);
            end
            ST_DISP: begin
                slot_addr = free_idx;
                slot_we = free_any;
                slot_wd = {32'd0, in_reg.dst_used, in_reg.dst_reg, in_reg.src_b_used,
                           in_reg.src_b, in_reg.src_a_used, in_reg.src_a, in_reg.op_tag};
            end
            ST_PRESET: begin
                u_addr = AW'(in_reg.dst_reg);
                u_wd = in_reg.preset_count;
                u_we = (32'(in_reg.dst_reg) < PHYS_REG_COUNT);
            end
            ST_ISCAN_W: begin
                slot_we = busy_reg[idx_reg] && !issued_reg[idx_reg] && src_a_ok && src_b_ok
                          && budget_reg != 4'd0;
                slot_wd = {now_reg + 32'(lat_reg), rd_dst, rd_src, rd_tag};
            end
            ST_SRC_WB: begin
                u_we = srcv_reg;
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ow_reg.kind;
    assign m_tdata  = {7'd0, ow_reg[$bits(out_word_t)-1:3]};
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            iw_reg     <= 3'd2;
            lat_reg    <= 4'd1;
            now_reg    <= '0;
            busy_reg   <= '0;
            issued_reg <= '0;
            rdy_reg    <= '1;
            uval_reg   <= '0;
            ovalid_reg <= 1'b0;
            last_reg   <= 1'b0;
            pend_last_reg <= 1'b0;
            idx_reg    <= '0;
            budget_reg <= '0;
            busyu_reg  <= '0;
            src_sel_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_ISSUE_WIDTH) begin
                    iw_reg <= cfg_wdata[2:0];
                end else begin
                    lat_reg <= cfg_wdata;
                end
            end
            if (ovalid_reg && m_tready) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_reg <= s_word;
                        priority case (s_word.command)
                            CMD_TICK: begin
                                state_reg  <= ST_ISCAN;
                                idx_reg    <= '0;
                                busyu_reg  <= '0;
                                budget_reg <= (32'(iw_reg) > MAX_ISSUE) ? 4'(MAX_ISSUE)
                                                                          : 4'(iw_reg);
                            end
                            CMD_DISPATCH: state_reg <= ST_DISP;
                            CMD_PRESET:   state_reg <= ST_PRESET;
                            default:      state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_DISP: begin
                    if (free_any) begin
                        busy_reg[free_idx]   <= 1'b1;
                        issued_reg[free_idx] <= 1'b0;
                    end
                    pend_reg <= '{kind: KIND_DISPATCH, accepted: free_any, default: '0};
                    pend_last_reg <= 1'b1;
                    ret_reg   <= ST_IDLE;
                    state_reg <= ST_EMIT;
                end
                ST_PRESET: begin
                    if (32'(in_reg.dst_reg) < PHYS_REG_COUNT) begin
                        rdy_reg[AW'(in_reg.dst_reg)]  <= in_reg.preset_valid;
                        uval_reg[AW'(in_reg.dst_reg)] <= 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_ISCAN: state_reg <= ST_ISCAN_W;
                ST_ISCAN_W: begin
                    state_reg <= ST_ISCAN;
                    if (32'(idx_reg) == STATION_SLOTS - 1) begin
                        ret_reg <= ST_RSCAN;
                    end else begin
                        ret_reg <= ST_ISCAN;
                    end
                    if (slot_we) begin
                        issued_reg[idx_reg] <= 1'b1;
                        budget_reg <= budget_reg - 4'd1;
                        pend_reg <= '{kind: KIND_ISSUED, out_tag: rd_tag, default: '0};
                        pend_last_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end else if (32'(idx_reg) == STATION_SLOTS - 1) begin
                        state_reg <= ST_RSCAN;
                    end
                    idx_reg <= (32'(idx_reg) == STATION_SLOTS - 1) ? '0 : idx_reg + 1'b1;
                end
                ST_RSCAN: state_reg <= ST_RSCAN_W;
                ST_RSCAN_W: begin
                    src_sel_reg <= 1'b0;
                    if (busy_reg[idx_reg] && issued_reg[idx_reg] && rd_done <= now_reg) begin
                        if (rd_dst[6]) begin
                            if (32'(rd_dst[5:0]) < PHYS_REG_COUNT) begin
                                rdy_reg[AW'(rd_dst[5:0])] <= 1'b1;
                            end
                        end
                        busy_reg[idx_reg]   <= 1'b0;
                        issued_reg[idx_reg] <= 1'b0;
                        pend_reg <= '{kind: KIND_COMPLETED, out_tag: rd_tag, default: '0};
                        pend_last_reg <= 1'b0;
                        ret_reg   <= ST_SRC_RD;
                        state_reg <= ST_EMIT;
                    end else begin
                        if (busy_reg[idx_reg] && issued_reg[idx_reg]) begin
                            busyu_reg <= busyu_reg + 1'b1;
                        end
                        if (32'(idx_reg) == STATION_SLOTS - 1) begin
                            state_reg <= ST_SUMMARY;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_RSCAN;
                        end
                    end
                end
                ST_SRC_RD: begin
                    sreg_reg  <= RW'(cur_src[5:0]);
                    srcv_reg  <= cur_src[6] && (32'(cur_src[5:0]) < PHYS_REG_COUNT);
                    state_reg <= ST_SRC_W;
                end
                ST_SRC_W: state_reg <= ST_SRC_WB;
                ST_SRC_WB: begin
                    if (srcv_reg) begin
                        uval_reg[AW'(sreg_reg)] <= 1'b1;
                    end
                    src_sel_reg <= 1'b1;
                    if (src_sel_reg) begin
                        ret_reg <= ST_RSCAN;
                    end else begin
                        ret_reg <= ST_SRC_RD;
                    end
                    if (srcv_reg && !rdy_reg[AW'(sreg_reg)] && u_dec == 8'd0) begin
                        pend_reg <= '{kind: KIND_FREED, freed_reg: sreg_reg[5:0], default: '0};
                        pend_last_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end else if (src_sel_reg) begin
                        state_reg <= ST_RSCAN;
                    end else begin
                        state_reg <= ST_SRC_RD;
                    end
                    if (src_sel_reg) begin
                        if (32'(idx_reg) == STATION_SLOTS - 1) begin
                            ret_reg <= ST_SUMMARY;
                            if (!(srcv_reg && !rdy_reg[AW'(sreg_reg)] && u_dec == 8'd0)) begin
                                state_reg <= ST_SUMMARY;
                            end
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_SUMMARY: begin
                    pend_reg <= '{kind: KIND_SUMMARY,
                                  occupancy: 5'($countones(busy_reg)),
                                  busy_units: 5'(busyu_reg), default: '0};
                    pend_last_reg <= 1'b1;
                    now_reg   <= now_reg + 32'd1;
                    ret_reg   <= ST_IDLE;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!ovalid_reg || m_tready) begin
                        ow_reg     <= pend_reg;
                        last_reg   <= pend_last_reg;
                        ovalid_reg <= 1'b1;
                        state_reg  <= ret_reg;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[sim/tb_reservation_station_issue_complete_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reservation station issue/complete core testbench
// Drives dispatch, preset and tick commands through the input stream with
// random gaps and output stalls, predicts every result word in a scoreboard
// and checks the words as they leave, over several issue width and latency
// settings.
// ----------------------------------------------------------------------------
module tb_reservation_station_issue_complete_core;
    import rsic_pkg::*;

    localparam int SLOTS = 16;
    localparam int NREGS = 64;
    localparam int ISSUE_CAP = 4;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int SETTLE = 200;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] tag;
        logic [5:0] freed;
        logic       acc;
        logic [4:0] occ;
        logic [4:0] busy;
        logic       last;
    } rs_result_t;

    class station_scoreboard;
        rs_result_t   pending[$];
        int           errors;
        logic [2:0]   width_cfg;
        logic [3:0]   lat_cfg;
        bit           busy_q[SLOTS];
        bit           issued_q[SLOTS];
        logic [7:0]   tag_q[SLOTS];
        in_word_t     op_q[SLOTS];
        logic [31:0]  due_q[SLOTS];
        bit           ready_q[NREGS];
        logic [7:0]   users_q[NREGS];
        logic [31:0]  now;

        function new();
            width_cfg = 2;
            lat_cfg = 1;
            now = 0;
            errors = 0;
            for (int i = 0; i < SLOTS; i++) begin
                busy_q[i] = 0;
                issued_q[i] = 0;
            end
            for (int r = 0; r < NREGS; r++) begin
                ready_q[r] = 1;
                users_q[r] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [3:0] val);
            if (idx == REG_ISSUE_WIDTH) width_cfg = val[2:0];
            else lat_cfg = val;
        endfunction

        function void push(logic [2:0] k, logic [7:0] t, logic [5:0] f, logic a,
                           logic [4:0] o, logic [4:0] b, logic l);
            rs_result_t e;
            e.kind = k; e.tag = t; e.freed = f; e.acc = a; e.occ = o; e.busy = b; e.last = l;
            pending.push_back(e);
        endfunction

        function void note_input(in_word_t w);
            int budget;
            int nbusy;
            int nocc;
            bit acc;
            logic [5:0] r;
            if (w.command == CMD_DISPATCH) begin
                acc = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!busy_q[i]) begin
                        busy_q[i] = 1;
                        issued_q[i] = 0;
                        tag_q[i] = w.op_tag;
                        op_q[i] = w;
                        acc = 1;
                        break;
                    end
                end
                push(KIND_DISPATCH, 0, 0, acc, 0, 0, 1);
            end else if (w.command == CMD_PRESET) begin
                ready_q[w.dst_reg] = w.preset_valid;
                users_q[w.dst_reg] = w.preset_count;
            end else if (w.command == CMD_TICK) begin
                budget = (width_cfg > ISSUE_CAP) ? ISSUE_CAP : width_cfg;
                nbusy = 0;
                nocc = 0;
                for (int i = 0; i < SLOTS && budget > 0; i++) begin
                    if (!busy_q[i] || issued_q[i]) continue;
                    if (op_q[i].src_a_used && !ready_q[op_q[i].src_a]) continue;
                    if (op_q[i].src_b_used && !ready_q[op_q[i].src_b]) continue;
                    issued_q[i] = 1;
                    due_q[i] = now + lat_cfg;
                    budget--;
                    push(KIND_ISSUED, tag_q[i], 0, 0, 0, 0, 0);
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (!busy_q[i] || !issued_q[i]) continue;
                    if (due_q[i] > now) begin
                        nbusy++;
                        continue;
                    end
                    if (op_q[i].dst_used) ready_q[op_q[i].dst_reg] = 1;
                    push(KIND_COMPLETED, tag_q[i], 0, 0, 0, 0, 0);
                    for (int s = 0; s < 2; s++) begin
                        if (s == 0 ? !op_q[i].src_a_used : !op_q[i].src_b_used) continue;
                        r = (s == 0) ? op_q[i].src_a : op_q[i].src_b;
                        if (users_q[r] > 0) users_q[r]--;
                        if (!ready_q[r] && users_q[r] == 0) push(KIND_FREED, 0, r, 0, 0, 0, 0);
                    end
                    busy_q[i] = 0;
                    issued_q[i] = 0;
                end
                for (int i = 0; i < SLOTS; i++) if (busy_q[i]) nocc++;
                push(KIND_SUMMARY, 0, 0, 0, nocc, nbusy, 1);
                now++;
            end
        endfunction

        function void check_result(logic [2:0] kind, logic [31:0] data, logic last);
            rs_result_t e;
            logic [31:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word kind %0d data %h last %b", $time, kind, data, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            want = {7'd0, e.busy, e.occ, e.acc, e.freed, e.tag};
            if (kind !== e.kind || data !== want || last !== e.last) begin
                $display("%0t: mismatch expected kind %0d data %h last %b, got kind %0d data %h last %b",
                         $time, e.kind, want, e.last, kind, data, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_wdata;

    station_scoreboard sb;
    int cycles;
    int stall_left;
    bit calm;

    reservation_station_issue_complete_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial aclk = 0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else if (calm || $urandom_range(99) < 70) begin
            m_tready <= 1;
        end else begin
            m_tready <= 0;
            stall_left <= ($urandom_range(19) == 0) ? $urandom_range(40, 15) : $urandom_range(2);
        end
    end

    function automatic int pick_gap();
        if (calm) return 0;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 0;
            9: return $urandom_range(30, 10);
            default: return $urandom_range(3, 1);
        endcase
    endfunction

    task automatic send(in_word_t w);
        int gap;
        s_tdata <= w;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(w);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        cfg_we <= 0;
    endtask

    function automatic in_word_t make_word(logic [1:0] cmd, logic [7:0] tag,
                                           logic [6:0] a, logic [6:0] b, logic [6:0] d,
                                           logic pv, logic [7:0] pc);
        in_word_t w;
        w = {8'($urandom()), $urandom()};
        w.command = cmd;
        w.op_tag = tag;
        {w.src_a_used, w.src_a} = a;
        {w.src_b_used, w.src_b} = b;
        {w.dst_used, w.dst_reg} = d;
        w.preset_valid = pv;
        w.preset_count = pc;
        return w;
    endfunction

    function automatic logic [5:0] any_reg();
        return ($urandom_range(9) == 0) ? 6'($urandom()) : 6'($urandom_range(7));
    endfunction

    function automatic in_word_t random_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) return make_word(2'd3, 8'($urandom()), 7'($urandom()), 7'($urandom()),
                                       7'($urandom()), 1'($urandom()), 8'($urandom()));
        if (roll < 38) return make_word(CMD_DISPATCH, 8'($urandom()),
                                        {1'($urandom()), any_reg()},
                                        {1'($urandom()), any_reg()},
                                        {1'($urandom()), any_reg()}, 1'($urandom()),
                                        8'($urandom()));
        if (roll < 55) return make_word(CMD_PRESET, 8'($urandom()), 7'($urandom()),
                                        7'($urandom()),
                                        {1'($urandom()), any_reg()},
                                        $urandom_range(99) < 65,
                                        ($urandom_range(7) == 0) ? 8'($urandom())
                                                                 : 8'($urandom_range(3)));
        return make_word(CMD_TICK, 8'($urandom()), 7'($urandom()), 7'($urandom()),
                         7'($urandom()), 1'($urandom()), 8'($urandom()));
    endfunction

    initial begin
        logic [2:0] widths[5] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3};
        logic [3:0] lats[5] = '{4'd0, 4'd15, 4'd3, 4'd2, 4'd1};
        sb = new();
        cycles = 0;
        stall_left = 0;
        calm = 0;
        aresetn <= 0;
        s_tvalid <= 0;
        s_tdata <= '0;
        m_tready <= 0;
        cfg_we <= 0;
        cfg_index <= 0;
        cfg_wdata <= 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // One register used twice as a source is freed once per use.
        send(make_word(CMD_DISPATCH, 8'hFF, {1'b1, 6'd6}, {1'b1, 6'd6}, 7'd0, 0, 0));
        send(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
        send(make_word(CMD_PRESET, 0, 0, 0, {1'b0, 6'd6}, 0, 8'd1));
        send(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
        send(make_word(CMD_PRESET, 0, 0, 0, {1'b0, 6'd6}, 1, 8'd0));
        // A destination equal to its own source is made ready, so it is not freed.
        send(make_word(CMD_DISPATCH, 8'h00, {1'b1, 6'd63}, 7'd0, {1'b1, 6'd63}, 0, 0));
        send(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
        send(make_word(CMD_PRESET, 0, 0, 0, {1'b0, 6'd63}, 0, 8'd255));
        send(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
        send(make_word(CMD_PRESET, 0, 0, 0, {1'b0, 6'd63}, 1, 8'd0));
        send(make_word(2'd3, 8'hA5, 7'h7F, 7'h7F, 7'h7F, 1, 8'hFF));
        // Fill the station and overflow it by one.
        for (int i = 0; i < SLOTS + 1; i++)
            send(make_word(CMD_DISPATCH, 8'(i * 15), 7'd0, 7'd0, 7'd0, 0, 0));

        for (int p = 0; p < 5; p++) begin
            settle();
            write_reg(REG_ISSUE_WIDTH, {1'b0, widths[p]});
            write_reg(REG_EXEC_LATENCY, lats[p]);
            calm = (p == 3);
            for (int n = 0; n < 100; n++) send(random_word());
        end

        // Drain whatever is still waiting with a wide issue and short latency.
        settle();
        write_reg(REG_ISSUE_WIDTH, 4'd4);
        write_reg(REG_EXEC_LATENCY, 4'd0);
        for (int r = 0; r < NREGS; r++)
            send(make_word(CMD_PRESET, 0, 0, 0, {1'b0, 6'(r)}, 1, 8'd0));
        for (int n = 0; n < 6; n++) send(make_word(CMD_TICK, 0, 0, 0, 0, 0, 0));
        settle();

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[sim.f]
design/rsic_pkg.sv
design/rsic_ram.sv
design/reservation_station_issue_complete_core.sv
sim/tb_reservation_station_issue_complete_core.sv
